// File: rtl/core/b64d_pkg.sv
// Shared types, constants and the character decode function of the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned SEXTET_W  = 6;
  localparam int unsigned ACC_W     = 18;
  localparam int unsigned WORD_W    = 24;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;
  localparam logic [CHAR_W-1:0] LOWER_OFFSET = 8'd71;
  localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 8'd4;
  localparam logic [SEXTET_W-1:0] SEXTET_PLUS  = 6'd62;
  localparam logic [SEXTET_W-1:0] SEXTET_SLASH = 6'd63;

  localparam logic [1:0] QUARTET_THIRD = 2'd2;
  localparam logic [1:0] QUARTET_FOURTH = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_BAD_CHAR    = 2'd1,
    STAT_MID_QUARTET = 2'd2
  } status_e;

  // One queued job: up to three bytes, most significant byte goes out first.
  typedef struct packed {
    logic [WORD_W-1:0] bytes;
    logic [1:0]        cnt;      // number of words, 1..3
    logic              str_end;  // the job's last word closes the string
    status_e           status;
  } job_t;

  // Returns {bad, sextet}.
  function automatic logic [SEXTET_W:0] sextet_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    logic [SEXTET_W:0] r;
    t = '0;
    r = {1'b1, {SEXTET_W{1'b0}}};
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      t = c - CHAR_UPPER_A;
      r = {1'b0, t[SEXTET_W-1:0]};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      t = c - LOWER_OFFSET;
      r = {1'b0, t[SEXTET_W-1:0]};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      t = c + DIGIT_OFFSET;
      r = {1'b0, t[SEXTET_W-1:0]};
    end else if (c == CHAR_PLUS) begin
      r = {1'b0, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b0, SEXTET_SLASH};
    end else if (c == CHAR_PAD) begin
      r = {1'b0, CHAR_PAD[SEXTET_W-1:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/b64d_front.sv
// Front end: classify characters, collect quartets and build output jobs.
`timescale 1ns / 1ps

module b64d_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [b64d_pkg::CHAR_W-1:0] char_i,
  input  logic                      final_i,
  output logic                      push_o,
  output b64d_pkg::job_t            job_o,
  input  logic                      q_full_i
);
  import b64d_pkg::*;

  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [1:0]          pos_q, pos_d;
  logic                third_pad_q, third_pad_d;
  logic                discard_q, discard_d;
  logic [SEXTET_W:0]   dec;
  logic                accept;
  logic                is_pad;
  logic [WORD_W-1:0]   word;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign dec        = sextet_of(char_i);
  assign is_pad     = (char_i == CHAR_PAD);
  assign word       = {acc_q, dec[SEXTET_W-1:0]};

  always_comb begin
    acc_d       = acc_q;
    pos_d       = pos_q;
    third_pad_d = third_pad_q;
    discard_d   = discard_q;
    push_o      = 1'b0;
    job_o       = '{bytes: '0, cnt: 2'd1, str_end: 1'b1, status: STAT_OK};
    if (accept) begin
      if (discard_q) begin
        // drop until the final character
        if (final_i) begin
          discard_d = 1'b0;
        end
      end else if (dec[SEXTET_W]) begin
        push_o      = 1'b1;
        job_o       = '{bytes: '0, cnt: 2'd1, str_end: final_i, status: STAT_BAD_CHAR};
        acc_d       = '0;
        pos_d       = '0;
        third_pad_d = 1'b0;
        discard_d   = !final_i;
      end else if (pos_q != QUARTET_FOURTH) begin
        if (pos_q == QUARTET_THIRD) begin
          third_pad_d = is_pad;
        end
        acc_d = {acc_q[ACC_W-SEXTET_W-1:0], dec[SEXTET_W-1:0]};
        pos_d = pos_q + 2'd1;
        if (final_i) begin
          push_o      = 1'b1;
          job_o       = '{bytes: '0, cnt: 2'd1, str_end: 1'b1, status: STAT_MID_QUARTET};
          acc_d       = '0;
          pos_d       = '0;
          third_pad_d = 1'b0;
        end
      end else begin
        push_o = 1'b1;
        job_o.bytes   = word;
        job_o.str_end = final_i;
        job_o.status  = STAT_OK;
        if (final_i && third_pad_q) begin
          job_o.cnt = 2'd1;
        end else if (final_i && is_pad) begin
          job_o.cnt = 2'd2;
        end else begin
          job_o.cnt = 2'd3;
        end
        acc_d       = '0;
        pos_d       = '0;
        third_pad_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pos_q       <= '0;
      third_pad_q <= 1'b0;
      discard_q   <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      third_pad_q <= third_pad_d;
      discard_q   <= discard_d;
    end
  end

endmodule

// File: rtl/core/b64d_queue.sv
// Short job queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module b64d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output b64d_pkg::job_t pop_data_o,
  output logic           empty_o
);
  import b64d_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/core/b64d_back.sv
// Back end: unpack queued jobs into one output word per cycle while the output is ready.
`timescale 1ns / 1ps

module b64d_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  b64d_pkg::job_t              q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [b64d_pkg::CHAR_W-1:0] out_byte_o,
  output logic                        out_last_o,
  output logic                        out_end_o,
  output b64d_pkg::status_e           out_status_o
);
  import b64d_pkg::*;

  job_t       job_q, job_d;
  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic       last;
  logic       done;

  assign last = (idx_q == (job_q.cnt - 2'd1));
  assign done = vld_q && out_ready_i && last;
  assign q_pop_o = !q_empty_i && (!vld_q || done);

  assign out_valid_o  = vld_q;
  assign out_last_o   = last;
  assign out_end_o    = last && job_q.str_end;
  assign out_status_o = job_q.status;

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = job_q.bytes[23:16];
      2'd1:    out_byte_o = job_q.bytes[15:8];
      default: out_byte_o = job_q.bytes[7:0];
    endcase
  end

  always_comb begin
    job_d = job_q;
    idx_d = idx_q;
    vld_d = vld_q;
    if (q_pop_o) begin
      job_d = q_data_i;
      idx_d = '0;
      vld_d = 1'b1;
    end else if (done) begin
      vld_d = 1'b0;
    end else if (vld_q && out_ready_i) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

endmodule

// File: rtl/core/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder.
`timescale 1ns / 1ps

// Decodes base64 text, one character per input word, into bytes, one byte per
// output word. Mark the last character of each encoded string with tlast.
// A-Z, a-z, 0-9, '+' and '/' carry six bits each; '=' inside data decodes as
// 61. Every fourth character releases three bytes, most significant first; in
// the final quartet a '=' in the third place trims it to one byte and a '='
// only in the fourth place to two. An unknown character gives one error word
// (status 1, byte 0) and the rest of the string is dropped up to and including
// its final character; a string that ends mid-quartet gives one word with
// status 2. tlast on the output marks the last word caused by one input
// character; tuser carries the end-of-string flag and the status.
// Rate: one character is accepted every cycle while the queue is not full, and
// one byte leaves every cycle while the output is ready and bytes wait. The
// front end classifies characters and writes one job per quartet, bad character
// or mid-quartet end into a four-entry queue; the back end drains a job one
// byte at a time. Since a quartet of four characters yields at most three
// bytes, input stalls only when the output side is held off.
module base64_stream_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tlast_i,   // final_char
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tlast_o,   // run_last
  output logic [2:0] m_axis_tuser_o    // [0] string_end, [2:1] status
);
  import b64d_pkg::*;

  job_t    push_job, pop_job;
  logic    push, pop, q_full, q_empty;
  logic    out_end;
  status_e out_status;

  // Classify and assemble quartets.
  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .char_i     (s_axis_tdata_i),
    .final_i    (s_axis_tlast_i),
    .push_o     (push),
    .job_o      (push_job),
    .q_full_i   (q_full)
  );

  // Decouple character intake from byte delivery.
  b64d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (q_empty)
  );

  // Emit one byte per accepted output word.
  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (pop_job),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_end_o    (out_end),
    .out_status_o (out_status)
  );

  assign m_axis_tuser_o = {out_status, out_end};

endmodule

// File: rtl/core/b64d_checker.sv
// Port-level checks for the base64 stream decoder, bound to the top level.
`timescale 1ns / 1ps

module b64d_assertions (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [2:0] m_axis_tuser_o
);
  import b64d_pkg::*;

  // Hold a stalled output word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // End of string only on the last word of a run.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o)
    else $error("string end without run end");

  // Error words are single, zero and last.
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:1] != STAT_OK)
      |-> m_axis_tlast_o && (m_axis_tdata_o == 8'd0))
    else $error("malformed error word");

  // Mid-quartet end always closes the string.
  a_mid_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:1] == STAT_MID_QUARTET) |-> m_axis_tuser_o[0])
    else $error("mid-quartet word does not close the string");

endmodule

bind base64_stream_decoder_top b64d_assertions u_b64d_assertions (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// File: test/b64d_checker.sv
// Checker that predicts the decoded output words of the base64 stream decoder and compares them.
`timescale 1ns / 1ps

module b64d_checker
  import b64d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,   // final_char
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [7:0] data_byte
  input  logic        m_axis_tlast_i,   // run_last
  input  logic [2:0]  m_axis_tuser_i,   // [0] string_end, [2:1] status
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  localparam logic [SEXTET_W-1:0] PAD_VALUE = 6'd61;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
    status_e    status;
  } byte_word_t;

  byte_word_t           byte_q[$];
  logic [ACC_W-1:0]     acc;
  logic [1:0]           qpos;
  logic                 third_pad;
  logic                 dropping;

  // {invalid, value}
  function automatic logic [SEXTET_W:0] char_value(input logic [7:0] c);
    logic [7:0] idx;
    idx = 8'h00;
    char_value = {1'b1, {SEXTET_W{1'b0}}};
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      idx = c - CHAR_UPPER_A;
      char_value = {1'b0, idx[SEXTET_W-1:0]};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      idx = (c - CHAR_LOWER_A) + 8'd26;
      char_value = {1'b0, idx[SEXTET_W-1:0]};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      idx = (c - CHAR_DIGIT_0) + 8'd52;
      char_value = {1'b0, idx[SEXTET_W-1:0]};
    end else if (c == CHAR_PLUS) begin
      char_value = {1'b0, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      char_value = {1'b0, SEXTET_SLASH};
    end else if (c == CHAR_PAD) begin
      char_value = {1'b0, PAD_VALUE};
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic run_last,
                            input logic str_end, input status_e status);
    byte_word_t w;
    w.data     = data;
    w.run_last = run_last;
    w.str_end  = str_end;
    w.status   = status;
    byte_q.push_back(w);
  endtask

  task automatic reset_quartet();
    acc       = '0;
    qpos      = '0;
    third_pad = 1'b0;
    dropping  = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic fin);
    logic [SEXTET_W:0] cv;
    logic [WORD_W-1:0] word;
    int                n;
    cv   = char_value(c);
    word = '0;
    n    = 3;
    if (dropping) begin
      // Swallow the rest of a broken string; its final char ends the drop.
      if (fin) reset_quartet();
    end else if (cv[SEXTET_W]) begin
      queue_byte(8'h00, 1'b1, fin, STAT_BAD_CHAR);
      reset_quartet();
      dropping = !fin;
    end else if (qpos != QUARTET_FOURTH) begin
      if (qpos == QUARTET_THIRD) third_pad = (c == CHAR_PAD);
      acc  = {acc[ACC_W-SEXTET_W-1:0], cv[SEXTET_W-1:0]};
      qpos = qpos + 2'd1;
      if (fin) begin
        queue_byte(8'h00, 1'b1, 1'b1, STAT_MID_QUARTET);
        reset_quartet();
      end
    end else begin
      word = {acc, cv[SEXTET_W-1:0]};
      if (fin) begin
        if (third_pad) n = 1;
        else if (c == CHAR_PAD) n = 2;
      end
      queue_byte(word[23:16], n == 1, fin && n == 1, STAT_OK);
      if (n >= 2) queue_byte(word[15:8], n == 2, fin && n == 2, STAT_OK);
      if (n == 3) queue_byte(word[7:0], 1'b1, fin, STAT_OK);
      reset_quartet();
    end
  endtask

  task automatic check_word();
    byte_word_t w;
    if (byte_q.size() == 0) begin
      report_mismatch($sformatf("unexpected output word data=%02h", m_axis_tdata_i));
    end else begin
      w = byte_q.pop_front();
      if (m_axis_tdata_i != w.data)
        report_mismatch($sformatf("data_byte got %02h expected %02h", m_axis_tdata_i, w.data));
      if (m_axis_tlast_i != w.run_last)
        report_mismatch($sformatf("run_last got %0b expected %0b", m_axis_tlast_i, w.run_last));
      if (m_axis_tuser_i[0] != w.str_end)
        report_mismatch($sformatf("string_end got %0b expected %0b",
                                  m_axis_tuser_i[0], w.str_end));
      if (m_axis_tuser_i[2:1] != w.status)
        report_mismatch($sformatf("status got %0d expected %0d",
                                  m_axis_tuser_i[2:1], w.status));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_quartet();
      byte_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) decode_char(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) check_word();
      pending_o = byte_q.size();
    end
  end

endmodule

// File: test/base64_stream_decoder_top_tb.sv
// Testbench top of the base64 stream decoder: character stimulus, output back-pressure, verdict.
`timescale 1ns / 1ps

module base64_stream_decoder_top_tb;
  import b64d_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int TOTAL_CHARS  = 120;
  localparam int HOLD_START   = 40;   // receiver cycle count at which the long hold-off starts
  localparam int HOLD_CYCLES  = 80;   // long enough to fill the job queue and stall input
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] c;
    logic       fin;
  } char_item_t;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;     // [7:0] char_code
  logic        s_last;     // final_char
  logic        m_valid;
  logic        m_ready;
  logic [7:0]  m_data;     // [7:0] data_byte
  logic        m_last;     // run_last
  logic [2:0]  m_user;     // [0] string_end, [2:1] status
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  char_item_t  char_q[$];

  base64_stream_decoder_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  // Watch both channels beside the block; it predicts every output word.
  b64d_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tlast_i  (m_last),
    .m_axis_tuser_i  (m_user),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Map an index 0..63 onto its base64 character.
  function automatic logic [7:0] b64_char(input int idx);
    if (idx < 26)      b64_char = CHAR_UPPER_A + 8'(idx);
    else if (idx < 52) b64_char = CHAR_LOWER_A + 8'(idx - 26);
    else if (idx < 62) b64_char = CHAR_DIGIT_0 + 8'(idx - 52);
    else if (idx == 62) b64_char = CHAR_PLUS;
    else               b64_char = CHAR_SLASH;
  endfunction

  // Return 1 for any character the decoder maps to a value, pad included.
  function automatic bit is_b64(input logic [7:0] c);
    is_b64 = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
             c == CHAR_PLUS || c == CHAR_SLASH || c == CHAR_PAD;
  endfunction

  function automatic logic [7:0] rand_good();
    rand_good = b64_char($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] rand_bad();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_b64(c)) c = 8'($urandom_range(0, 255));
    rand_bad = c;
  endfunction

  task automatic push_char(input logic [7:0] c, input logic fin);
    char_item_t it;
    it.c   = c;
    it.fin = fin;
    char_q.push_back(it);
  endtask

  // Queue a text literal; mark its last character as final when asked.
  task automatic push_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) push_char(s[i], fin && (i == s.len() - 1));
  endtask

  // Queue one well-formed string; its final quartet gets a random pad shape.
  task automatic push_good_string();
    int nq;
    int pad_kind;
    nq       = $urandom_range(1, 3);
    pad_kind = $urandom_range(0, 3);
    for (int q = 0; q < nq - 1; q++)
      for (int k = 0; k < 4; k++) push_char(rand_good(), 1'b0);
    push_char(rand_good(), 1'b0);
    push_char(rand_good(), 1'b0);
    case (pad_kind)
      0: begin
        push_char(rand_good(), 1'b0);
        push_char(rand_good(), 1'b1);
      end
      1: begin
        push_char(rand_good(), 1'b0);
        push_char(CHAR_PAD, 1'b1);
      end
      2: begin
        push_char(CHAR_PAD, 1'b0);
        push_char(CHAR_PAD, 1'b1);
      end
      default: begin
        push_char(CHAR_PAD, 1'b0);
        push_char(rand_good(), 1'b1);
      end
    endcase
  endtask

  // Queue one string of a random shape: mostly well-formed, the rest broken or noise.
  task automatic push_random_string();
    int kind;
    int len;
    int bad_at;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4, 5: push_good_string();
      6: begin
        // End the string one to three characters into a quartet.
        len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
        for (int i = 0; i < len; i++) push_char(rand_good(), i == len - 1);
      end
      7: begin
        // Put an unknown character somewhere; the decoder drops everything after it.
        len    = $urandom_range(1, 9);
        bad_at = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++)
          push_char((i == bad_at) ? rand_bad() : rand_good(), i == len - 1);
      end
      8: begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) push_char(8'($urandom_range(0, 255)), i == len - 1);
      end
      default: begin
        // Scatter pads over whole quartets, in and out of the final one.
        len = 4 * $urandom_range(1, 2);
        for (int i = 0; i < len; i++)
          push_char(($urandom_range(0, 2) == 0) ? CHAR_PAD : rand_good(), i == len - 1);
      end
    endcase
  endtask

  // Offer one character and hold it until the block takes it.
  task automatic send_char(input char_item_t it);
    s_valid <= 1'b1;
    s_data  <= it.c;
    s_last  <= it.fin;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  // Sender: directed strings, then random strings, in bursts with random gaps.
  initial begin : sender
    int burst_left;
    int idx;
    rst_n   = 1'b0;
    s_valid = 1'b0;
    s_data  = 8'h00;
    s_last  = 1'b0;

    // Directed part: full quartet, pad in the first place, pad in the fourth.
    push_text("TWFu", 1'b0);
    push_text("=/+9", 1'b0);
    push_text("az0=", 1'b1);
    // Double pad, then pad in the third place only.
    push_text("TQ==", 1'b1);
    push_text("TQ=x", 1'b1);
    // End mid-quartet.
    push_text("AZ", 1'b1);
    // Unknown character as the final one, then one that starts a drop.
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b0);
    push_text("ab", 1'b1);

    while (char_q.size() < TOTAL_CHARS) push_random_string();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    burst_left = 0;
    idx        = 0;
    while (idx < char_q.size()) begin
      if (burst_left == 0) begin
        // Drop valid for a gap, then start a new burst; some bursts run long.
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                 : $urandom_range(1, 10);
      end
      send_char(char_q[idx]);
      idx++;
      burst_left--;
    end
    s_valid <= 1'b0;

    // Wait for every predicted word, then give the block time to show strays.
    while (pending_cnt != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: stretches of random ready patterns, with one long hold-off early on.
  initial begin : receiver
    int cycle_cnt;
    int mode;
    int stretch;
    int period;
    bit held;
    m_ready   = 1'b0;
    cycle_cnt = 0;
    held      = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(8, 40);
      period  = $urandom_range(2, 4);
      for (int k = 0; k < stretch; k++) begin
        if (!held && cycle_cnt >= HOLD_START) begin
          // Hold off while the sender keeps offering; the queue fills up.
          held = 1'b1;
          m_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          cycle_cnt += HOLD_CYCLES;
        end else begin
          case (mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (cycle_cnt % period == 0);
          endcase
          @(negedge clk);
          cycle_cnt++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin : watchdog
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder_top.sv
rtl/core/b64d_checker.sv
test/b64d_checker.sv
test/base64_stream_decoder_top_tb.sv
